// ----- hdl/gpc_pkg.sv -----
// Shared types and constants for the grid path counter.
`default_nettype none

package gpc_pkg;

  localparam int COUNT_W = 30;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int ROW_W   = 10;

  localparam logic [COUNT_W-1:0] PATH_MOD  = 30'd1000000007;
  localparam logic [CFG_W-1:0]   ROW_LIMIT = 11'd1024;

  localparam logic [IDX_W-1:0] REG_NUM_COLS = 2'd0;
  localparam logic [IDX_W-1:0] REG_NUM_ROWS = 2'd1;

  typedef struct packed {
    logic first_row;
    logic first_col;
    logic is_last;
  } cell_pos_t;

endpackage

`default_nettype wire

// ----- hdl/grid_path_counter_top.sv -----
// Top level of the grid path counter: read stage, modular add and output register.
`default_nettype none

// Counts right/down paths through a grid of up to MAX_COLS by 1024 cells, modulo
// 1000000007. Cells enter in row-major order, one per beat, and each gives one result
// beat with its path count; the bottom-right cell is marked with out_is_last, after
// which the next beat starts a new grid. The block takes one cell every clock cycle
// while out_ready keeps the output moving. A result passes through the stage-one
// registers to the output register: the row buffer read is issued as the cell is
// taken, and the add and reduction are done in stage one, which holds while the
// output is stalled. The row buffer is a single memory of MAX_COLS entries with a
// registered read; a value written back is forwarded to a read of the same column
// issued while it is written. Writing a grid size register returns the position
// to the top-left cell; write it only while idle. No clearing pass follows reset.
module grid_path_counter_top #(
  parameter int MAX_COLS = 1024
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire  [gpc_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [gpc_pkg::CFG_W-1:0]   cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_blocked,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [gpc_pkg::COUNT_W-1:0] out_path_count,
  output logic                        out_is_last
);

  localparam int COL_W = $clog2(MAX_COLS);

  logic                        in_fire;
  logic                        s1_fire;
  logic [COL_W-1:0]            cur_col;
  gpc_pkg::cell_pos_t          cur_pos;

  logic                        s1_valid_r;
  logic                        s1_blocked_r;
  logic [COL_W-1:0]            s1_col_r;
  gpc_pkg::cell_pos_t          s1_pos_r;
  logic                        fwd_r;
  logic [gpc_pkg::COUNT_W-1:0] fwd_data_r;
  logic [gpc_pkg::COUNT_W-1:0] left_r;
  logic                        out_valid_r;
  logic [gpc_pkg::COUNT_W-1:0] out_count_r;
  logic                        out_last_r;

  logic [gpc_pkg::COUNT_W-1:0] rd_data;
  logic [gpc_pkg::COUNT_W-1:0] above;
  logic [gpc_pkg::COUNT_W-1:0] left;
  logic [gpc_pkg::COUNT_W:0]   sum;
  logic [gpc_pkg::COUNT_W-1:0] count;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  gpc_cursor #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_fire),
    .col       (cur_col),
    .pos       (cur_pos)
  );

  gpc_row_ram #(
    .DEPTH  (MAX_COLS),
    .ADDR_W (COL_W)
  ) u_row_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (cur_col),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_col_r),
    .wr_data (count)
  );

  always_comb begin
    if (s1_pos_r.first_row) begin
      above = '0;
    end else if (fwd_r) begin
      above = fwd_data_r;
    end else begin
      above = rd_data;
    end
    left = s1_pos_r.first_col ? '0 : left_r;
    sum  = {1'b0, above} + {1'b0, left};
    if (sum >= {1'b0, gpc_pkg::PATH_MOD}) begin
      sum = sum - {1'b0, gpc_pkg::PATH_MOD};
    end
    priority if (s1_pos_r.first_row && s1_pos_r.first_col) begin
      count = gpc_pkg::COUNT_W'(1);
    end else if (s1_blocked_r) begin
      count = '0;
    end else begin
      count = sum[gpc_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_blocked_r <= in_blocked;
      s1_col_r     <= cur_col;
      s1_pos_r     <= cur_pos;
      fwd_r        <= s1_fire && (s1_col_r == cur_col);
      fwd_data_r   <= count;
    end
    if (s1_fire) begin
      left_r      <= count;
      out_count_r <= count;
      out_last_r  <= s1_pos_r.is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_path_count = out_count_r;
  assign out_is_last    = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/gpc_row_ram.sv -----
// Row buffer memory with one write port and one registered read port.
`default_nettype none

module gpc_row_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire                         clk,
  input  wire                         rd_en,
  input  wire  [ADDR_W-1:0]           rd_addr,
  output logic [gpc_pkg::COUNT_W-1:0] rd_data,
  input  wire                         wr_en,
  input  wire  [ADDR_W-1:0]           wr_addr,
  input  wire  [gpc_pkg::COUNT_W-1:0] wr_data
);

  logic [gpc_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gpc_cursor.sv -----
// Grid size registers and the row and column position of the next cell.
`default_nettype none

module gpc_cursor #(
  parameter int MAX_COLS = 1024,
  parameter int COL_W    = 10
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [gpc_pkg::IDX_W-1:0]        cfg_index,
  input  wire  [gpc_pkg::CFG_W-1:0]        cfg_data,
  input  wire                              advance,
  output logic [COL_W-1:0]                 col,
  output gpc_pkg::cell_pos_t               pos
);

  localparam int CMP_W = (COL_W + 1 > gpc_pkg::CFG_W) ? COL_W + 1 : gpc_pkg::CFG_W;

  logic [gpc_pkg::CFG_W-1:0] num_cols_r;
  logic [gpc_pkg::CFG_W-1:0] num_rows_r;
  logic [COL_W-1:0]          col_r;
  logic [gpc_pkg::ROW_W-1:0] row_r;
  logic [COL_W-1:0]          col_nxt;
  logic [gpc_pkg::ROW_W-1:0] row_nxt;
  logic [CMP_W-1:0]          cols_ext;
  logic [COL_W-1:0]          last_col;
  logic [gpc_pkg::ROW_W-1:0] last_row;
  logic                      at_last_col;

  assign cols_ext = CMP_W'(num_cols_r);

  always_comb begin
    if (num_cols_r == '0) begin
      last_col = '0;
    end else if (cols_ext > CMP_W'(MAX_COLS)) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(cols_ext - CMP_W'(1));
    end
  end

  always_comb begin
    if (num_rows_r == '0) begin
      last_row = '0;
    end else if (num_rows_r > gpc_pkg::ROW_LIMIT) begin
      last_row = gpc_pkg::ROW_W'(gpc_pkg::ROW_LIMIT - 11'd1);
    end else begin
      last_row = gpc_pkg::ROW_W'(num_rows_r - 11'd1);
    end
  end

  assign at_last_col   = (col_r == last_col);
  assign col           = col_r;
  assign pos.first_row = (row_r == '0);
  assign pos.first_col = (col_r == '0);
  assign pos.is_last   = at_last_col && (row_r == last_row);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      priority if (pos.is_last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (at_last_col) begin
        col_nxt = '0;
        row_nxt = row_r + gpc_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= gpc_pkg::CFG_W'(1);
      num_rows_r <= gpc_pkg::CFG_W'(1);
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_we && (cfg_index == gpc_pkg::REG_NUM_COLS ||
                            cfg_index == gpc_pkg::REG_NUM_ROWS)) begin
      if (cfg_index == gpc_pkg::REG_NUM_COLS) begin
        num_cols_r <= cfg_data;
      end else begin
        num_rows_r <= cfg_data;
      end
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire
